### sv/htam_pkg.sv
// Shared types and constants for the heartbeat timeout alarm monitor.
`default_nettype none

package htam_pkg;

   typedef enum logic [1:0] {
      MODE_TICK     = 2'd0,
      MODE_BEAT     = 2'd1,
      MODE_REGISTER = 2'd2,
      MODE_ENABLE   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CSR_BEEP_ENABLE  = 2'd0,
      CSR_ALARM_PERIOD = 2'd1,
      CSR_BLINK_ON     = 2'd2,
      CSR_BLINK_CYCLE  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_RELOAD,
      ST_BLINK
   } state_type;

   localparam logic [1:0] LAMP_GREEN = 2'd0;
   localparam logic [1:0] LAMP_RED   = 2'd1;
   localparam logic [1:0] LAMP_DARK  = 2'd2;

   localparam logic        BEEP_ENABLE_RST  = 1'b1;
   localparam logic [15:0] ALARM_PERIOD_RST = 16'd2000;
   localparam logic [15:0] BLINK_ON_RST     = 16'd100;
   localparam logic [15:0] BLINK_CYCLE_RST  = 16'd200;

   typedef struct packed {
      mode_type    mode;
      logic [31:0] timestamp_ms;
      logic [3:0]  device_index;
      logic [31:0] device_timeout_ms;
      logic [7:0]  device_beep_count;
      logic        device_enable;
   } req_type;

   typedef struct packed {
      logic       addressed_offline;
      logic       buzzer_on;
      logic [1:0] led_colour;
      logic       silent_error;
      logic       audible_fault;
   } rsp_type;

endpackage

`default_nettype wire

### sv/htam_slot_ram.sv
// Per-slot storage: timeout and beep count in one memory, last heartbeat in another.
`default_nettype none

module htam_slot_ram #(
   parameter int MAX_SLOTS = 16,
   parameter int SLOT_W    = 4
) (
   input  wire logic              clock,
   input  wire logic              cfg_we,
   input  wire logic              seen_we,
   input  wire logic [SLOT_W-1:0] wr_addr,
   input  wire logic [31:0]       wr_timeout,
   input  wire logic [7:0]        wr_beeps,
   input  wire logic [31:0]       wr_seen,
   input  wire logic              rd_en,
   input  wire logic [SLOT_W-1:0] rd_addr,
   output logic      [31:0]       rd_timeout,
   output logic      [7:0]        rd_beeps,
   output logic      [31:0]       rd_seen
);

   logic [39:0] cfg_mem  [MAX_SLOTS];
   logic [31:0] seen_mem [MAX_SLOTS];
   logic [39:0] cfg_rd_ff;
   logic [31:0] seen_rd_ff;

   always_ff @(posedge clock) begin
      if (cfg_we) begin
         cfg_mem[wr_addr] <= {wr_timeout, wr_beeps};
      end
      if (rd_en) begin
         cfg_rd_ff <= cfg_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (seen_we) begin
         seen_mem[wr_addr] <= wr_seen;
      end
      if (rd_en) begin
         seen_rd_ff <= seen_mem[rd_addr];
      end
   end

   assign rd_timeout = cfg_rd_ff[39:8];
   assign rd_beeps   = cfg_rd_ff[7:0];
   assign rd_seen    = seen_rd_ff;

endmodule

`default_nettype wire

### sv/heartbeat_timeout_alarm_monitor.sv
// Top level: multi-slot heartbeat watchdog driving a buzzer and LED alarm pattern.
//
// Usage:
//  - Commands enter on req_data (packed struct) and transfer at a rising edge with
//    start high and busy low. Every command yields exactly one response on rsp_data,
//    marked by a one-cycle rsp_valid strobe; the receiver cannot stall it.
//  - Heartbeat, register and set-enable commands: the response strobes the
//    cycle after the transfer and busy stays low, so these commands may be
//    issued every cycle.
//  - A tick scans the slot memories one slot per cycle (one read port, read
//    data registered), compares the last slot in the cycle after, then runs
//    the alarm timing in the RELOAD and BLINK states. busy is high from the
//    transfer until the tick is done; the response strobes in the first cycle
//    with busy low, and no new command is taken while a tick is in progress.
//  - csr_we/csr_index/csr_wdata write the four timing registers;
//    write them only while the block is idle.
//  - Synchronous reset clears slot valid/enable/offline flags, the alarm timers
//    and outputs (LED green) and loads the register defaults. Slot memories are
//    not cleared: an entry's data is only used once a register command wrote it.
`default_nettype none

module heartbeat_timeout_alarm_monitor #(
   parameter int MAX_SLOTS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire htam_pkg::req_type req_data,
   output logic                  rsp_valid,
   output htam_pkg::rsp_type     rsp_data,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [15:0]      csr_wdata
);

   localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_SLOTS - 1);

   // configuration registers
   logic        beep_en_ff;
   logic [15:0] period_ff;
   logic [15:0] on_ff;
   logic [15:0] cycle_ff;

   // per-slot flags
   logic [MAX_SLOTS-1:0] slot_valid_ff;
   logic [MAX_SLOTS-1:0] slot_enabled_ff;
   logic [MAX_SLOTS-1:0] slot_offline_ff;

   // sequencer
   htam_pkg::state_type state_ff, state_in;
   logic [SLOT_W-1:0]   ptr_ff;
   logic                chk_vld_ff;
   logic [SLOT_W-1:0]   chk_idx_ff;
   logic                scan_rd;
   logic                in_reload;
   logic                in_blink;

   // latched tick command
   logic [31:0]       now_ff;
   logic [SLOT_W-1:0] tick_addr_ff;
   logic              tick_here_ff;

   // scan accumulators
   logic       loud_ff;
   logic       quiet_ff;
   logic [7:0] fewest_ff;

   // alarm state
   logic [31:0] period_start_ff, period_start_in;
   logic [31:0] blink_start_ff, blink_start_in;
   logic [7:0]  blinks_left_ff, blinks_left_in;
   logic        buzzer_ff, buzzer_in;
   logic [1:0]  led_ff, led_in;
   logic        silent_ff, silent_in;
   logic        audible_ff, audible_in;

   logic              rsp_valid_ff;
   htam_pkg::rsp_type rsp_ff;

   // command decode
   logic              accept;
   logic [31:0]       idx_wide;
   logic              here;
   logic [SLOT_W-1:0] req_addr;
   logic              req_valid_slot;
   logic              reg_we;
   logic              beat_we;
   logic              en_we;

   // memory read side
   logic [31:0] rd_timeout;
   logic [7:0]  rd_beeps;
   logic [31:0] rd_seen;
   logic        live;
   logic        late;
   logic [31:0] since_seen;
   logic [31:0] since_period;
   logic [31:0] blink_d;

   assign accept         = start & ~busy;
   assign idx_wide       = 32'(req_data.device_index);
   assign here           = idx_wide < 32'(MAX_SLOTS);
   assign req_addr       = idx_wide[SLOT_W-1:0];
   assign req_valid_slot = here && slot_valid_ff[req_addr];
   assign reg_we  = accept && (req_data.mode == htam_pkg::MODE_REGISTER) && here;
   assign beat_we = accept && (req_data.mode == htam_pkg::MODE_BEAT) && req_valid_slot;
   assign en_we   = accept && (req_data.mode == htam_pkg::MODE_ENABLE) && req_valid_slot;

   htam_slot_ram #(
      .MAX_SLOTS (MAX_SLOTS),
      .SLOT_W    (SLOT_W)
   ) u_slot_ram (
      .clock      (clock),
      .cfg_we     (reg_we),
      .seen_we    (reg_we | beat_we),
      .wr_addr    (req_addr),
      .wr_timeout (req_data.device_timeout_ms),
      .wr_beeps   (req_data.device_beep_count),
      .wr_seen    (req_data.timestamp_ms),
      .rd_en      (scan_rd),
      .rd_addr    (ptr_ff),
      .rd_timeout (rd_timeout),
      .rd_beeps   (rd_beeps),
      .rd_seen    (rd_seen)
   );

   // configuration port
   always_ff @(posedge clock) begin
      if (reset) begin
         beep_en_ff <= htam_pkg::BEEP_ENABLE_RST;
         period_ff  <= htam_pkg::ALARM_PERIOD_RST;
         on_ff      <= htam_pkg::BLINK_ON_RST;
         cycle_ff   <= htam_pkg::BLINK_CYCLE_RST;
      end else if (csr_we) begin
         unique case (htam_pkg::csr_index_type'(csr_index))
            htam_pkg::CSR_BEEP_ENABLE:  beep_en_ff <= csr_wdata[0];
            htam_pkg::CSR_ALARM_PERIOD: period_ff  <= csr_wdata;
            htam_pkg::CSR_BLINK_ON:     on_ff      <= csr_wdata;
            htam_pkg::CSR_BLINK_CYCLE:  cycle_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         htam_pkg::ST_IDLE: begin
            if (accept && (req_data.mode == htam_pkg::MODE_TICK)) state_in = htam_pkg::ST_SCAN;
         end
         htam_pkg::ST_SCAN: begin
            if (ptr_ff == LAST_SLOT) state_in = htam_pkg::ST_DRAIN;
         end
         htam_pkg::ST_DRAIN:  state_in = htam_pkg::ST_RELOAD;
         htam_pkg::ST_RELOAD: state_in = htam_pkg::ST_BLINK;
         htam_pkg::ST_BLINK:  state_in = htam_pkg::ST_IDLE;
         default:             state_in = htam_pkg::ST_IDLE;
      endcase
   end

   // state decode
   always_comb begin
      busy      = (state_ff != htam_pkg::ST_IDLE);
      scan_rd   = (state_ff == htam_pkg::ST_SCAN);
      in_reload = (state_ff == htam_pkg::ST_RELOAD);
      in_blink  = (state_ff == htam_pkg::ST_BLINK);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= htam_pkg::ST_IDLE;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         chk_vld_ff <= scan_rd;
      end
   end

   // scan pointer, compare-stage tag and latched tick command
   always_ff @(posedge clock) begin
      chk_idx_ff <= ptr_ff;
      if (accept && (req_data.mode == htam_pkg::MODE_TICK)) begin
         ptr_ff       <= '0;
         now_ff       <= req_data.timestamp_ms;
         tick_addr_ff <= req_addr;
         tick_here_ff <= here;
      end else if (scan_rd) begin
         ptr_ff <= ptr_ff + SLOT_W'(1);
      end
   end

   // compare stage: one slot per cycle against registered memory data
   assign since_seen = now_ff - rd_seen;
   assign live = chk_vld_ff && slot_valid_ff[chk_idx_ff] && slot_enabled_ff[chk_idx_ff];
   assign late = since_seen > rd_timeout;

   always_ff @(posedge clock) begin
      if (accept && (req_data.mode == htam_pkg::MODE_TICK)) begin
         loud_ff   <= 1'b0;
         quiet_ff  <= 1'b0;
         fewest_ff <= '0;
      end else if (live && late) begin
         if (rd_beeps != 8'd0) begin
            loud_ff <= 1'b1;
            if ((fewest_ff == 8'd0) || (rd_beeps < fewest_ff)) fewest_ff <= rd_beeps;
         end else begin
            quiet_ff <= 1'b1;
         end
      end
   end

   // slot flags
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff   <= '0;
         slot_enabled_ff <= '0;
         slot_offline_ff <= '0;
      end else begin
         if (live) slot_offline_ff[chk_idx_ff] <= late;
         if (reg_we) begin
            slot_valid_ff[req_addr]   <= 1'b1;
            slot_enabled_ff[req_addr] <= req_data.device_enable;
            slot_offline_ff[req_addr] <= 1'b0;
         end
         if (en_we) slot_enabled_ff[req_addr] <= req_data.device_enable;
      end
   end

   // alarm timing: period reload, then blink phase
   assign since_period = now_ff - period_start_ff;
   assign blink_d      = now_ff - blink_start_ff;

   always_comb begin
      period_start_in = period_start_ff;
      blink_start_in  = blink_start_ff;
      blinks_left_in  = blinks_left_ff;
      buzzer_in       = buzzer_ff;
      led_in          = led_ff;
      silent_in       = silent_ff;
      audible_in      = audible_ff;
      if (in_reload) begin
         audible_in = loud_ff;
         silent_in  = ~loud_ff & quiet_ff;
         if (silent_in) begin
            // only silent slots down: steady red, pattern restarts later
            buzzer_in       = 1'b0;
            led_in          = htam_pkg::LAMP_RED;
            blinks_left_in  = '0;
            period_start_in = now_ff;
         end else if (since_period > 32'(period_ff)) begin
            blinks_left_in  = fewest_ff;
            period_start_in = now_ff;
            blink_start_in  = now_ff;
         end
      end else if (in_blink && !silent_ff) begin
         if (blinks_left_ff != 8'd0) begin
            if (blink_d < 32'(on_ff)) begin
               buzzer_in = beep_en_ff;
               led_in    = htam_pkg::LAMP_RED;
            end else if (blink_d < 32'(cycle_ff)) begin
               buzzer_in = 1'b0;
               led_in    = htam_pkg::LAMP_DARK;
            end else begin
               // blink done: outputs hold, next blink starts now
               blinks_left_in = blinks_left_ff - 8'd1;
               blink_start_in = now_ff;
            end
         end else begin
            buzzer_in = 1'b0;
            led_in    = (fewest_ff != 8'd0) ? htam_pkg::LAMP_DARK : htam_pkg::LAMP_GREEN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_start_ff <= '0;
         blink_start_ff  <= '0;
         blinks_left_ff  <= '0;
         buzzer_ff       <= 1'b0;
         led_ff          <= htam_pkg::LAMP_GREEN;
         silent_ff       <= 1'b0;
         audible_ff      <= 1'b0;
      end else begin
         period_start_ff <= period_start_in;
         blink_start_ff  <= blink_start_in;
         blinks_left_ff  <= blinks_left_in;
         buzzer_ff       <= buzzer_in;
         led_ff          <= led_in;
         silent_ff       <= silent_in;
         audible_ff      <= audible_in;
      end
   end

   // response register: non-tick commands answer at once, ticks after the blink step
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= in_blink || (accept && (req_data.mode != htam_pkg::MODE_TICK));
      end
   end

   always_ff @(posedge clock) begin
      if (in_blink) begin
         rsp_ff.addressed_offline <= ~(tick_here_ff && slot_valid_ff[tick_addr_ff]
                                       && !slot_offline_ff[tick_addr_ff]);
         rsp_ff.buzzer_on    <= buzzer_in;
         rsp_ff.led_colour   <= led_in;
         rsp_ff.silent_error <= silent_in;
         rsp_ff.audible_fault <= audible_in;
      end else if (accept) begin
         if (req_data.mode == htam_pkg::MODE_REGISTER) begin
            rsp_ff.addressed_offline <= ~here;
         end else begin
            rsp_ff.addressed_offline <= ~(req_valid_slot && !slot_offline_ff[req_addr]);
         end
         rsp_ff.buzzer_on     <= buzzer_ff;
         rsp_ff.led_colour    <= led_ff;
         rsp_ff.silent_error  <= silent_ff;
         rsp_ff.audible_fault <= audible_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

### sim/tb_heartbeat_timeout_alarm_monitor.sv
// Self-checking testbench for the heartbeat timeout alarm monitor.
`timescale 1ns / 100ps

module tb_heartbeat_timeout_alarm_monitor;

   localparam int NSLOTS      = 16;
   localparam int TAIL_CYCLES = NSLOTS + 8;     // one full tick plus margin
   localparam int CYCLE_LIMIT = 400000;         // many times the slowest legal run

   // ------------------------------------------------------------------
   // Clock, reset and DUT pins; every input starts at a known value
   // ------------------------------------------------------------------
   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              start     = 1'b0;
   logic              busy;
   htam_pkg::req_type cmd       = '0;
   logic              rsp_valid;
   htam_pkg::rsp_type rsp;
   logic              csr_we    = 1'b0;
   logic [1:0]        csr_index = '0;
   logic [15:0]       csr_wdata = '0;

   always #5 clock = ~clock;

   heartbeat_timeout_alarm_monitor #(
      .MAX_SLOTS (NSLOTS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (cmd),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ------------------------------------------------------------------
   // Predictor state: slot table, alarm timers, held outputs, settings
   // ------------------------------------------------------------------
   logic        tbl_valid   [NSLOTS];
   logic        tbl_enabled [NSLOTS];
   logic [31:0] tbl_timeout [NSLOTS];
   logic [7:0]  tbl_beeps   [NSLOTS];
   logic [31:0] tbl_seen    [NSLOTS];
   logic        tbl_down    [NSLOTS];
   logic [31:0] per_start;
   logic [31:0] blk_start;
   logic [7:0]  blk_left;
   logic        out_buzz;
   logic [1:0]  out_led;
   logic        out_silent;
   logic        out_audible;

   logic        cfg_beep;
   logic [15:0] cfg_period;
   logic [15:0] cfg_on;
   logic [15:0] cfg_cycle;

   // Commands waiting for the driver, and status words waiting for the DUT
   htam_pkg::req_type pending_cmds [$];
   htam_pkg::rsp_type expected_status [$];

   int          mismatches  = 0;
   int          cmds_sent   = 0;
   int          ticks_sent  = 0;
   int          status_seen = 0;
   int          settings_used = 0;
   int          cycle_count = 0;
   logic        steady      = 1'b0;   // last part of the run: no sender gaps
   logic [31:0] now_ms      = '0;     // stimulus wall clock

   // Apply one command to the predictor; returns the status the DUT must report.
   function automatic htam_pkg::rsp_type predict_status(htam_pkg::req_type c);
      htam_pkg::rsp_type r;
      logic        loud;
      logic        quiet;
      logic [7:0]  fewest;
      logic [7:0]  wanted;
      logic [31:0] age;
      logic [3:0]  ix;
      int          i;
      ix = c.device_index;
      case (c.mode)
         htam_pkg::MODE_TICK: begin
            loud   = 1'b0;
            quiet  = 1'b0;
            fewest = '0;
            for (i = 0; i < NSLOTS; i++) begin
               // disabled slots keep whatever offline flag they had
               if (tbl_valid[i] && tbl_enabled[i]) begin
                  age = c.timestamp_ms - tbl_seen[i];
                  tbl_down[i] = (age > tbl_timeout[i]);
                  if (tbl_down[i]) begin
                     if (tbl_beeps[i] != 0) begin
                        loud = 1'b1;
                        if (fewest == 0 || tbl_beeps[i] < fewest) fewest = tbl_beeps[i];
                     end else begin
                        quiet = 1'b1;
                     end
                  end
               end
            end
            out_audible = loud;
            out_silent  = !loud && quiet;
            wanted      = loud ? fewest : 8'd0;
            if (out_silent) begin
               // only silent slots down: steady red, pattern restarts later
               out_buzz  = 1'b0;
               out_led   = htam_pkg::LAMP_RED;
               blk_left  = '0;
               per_start = c.timestamp_ms;
            end else begin
               age = c.timestamp_ms - per_start;
               if (age > {16'd0, cfg_period}) begin
                  blk_left  = wanted;
                  per_start = c.timestamp_ms;
                  blk_start = c.timestamp_ms;
               end
               if (blk_left != 0) begin
                  age = c.timestamp_ms - blk_start;
                  if (age < {16'd0, cfg_on}) begin
                     out_buzz = cfg_beep;
                     out_led  = htam_pkg::LAMP_RED;
                  end else if (age < {16'd0, cfg_cycle}) begin
                     out_buzz = 1'b0;
                     out_led  = htam_pkg::LAMP_DARK;
                  end else begin
                     // blink done: outputs hold, next blink starts now
                     blk_left  = blk_left - 8'd1;
                     blk_start = c.timestamp_ms;
                  end
               end else begin
                  out_buzz = 1'b0;
                  out_led  = (wanted != 0) ? htam_pkg::LAMP_DARK : htam_pkg::LAMP_GREEN;
               end
            end
         end
         htam_pkg::MODE_BEAT: begin
            if (tbl_valid[ix]) tbl_seen[ix] = c.timestamp_ms;
         end
         htam_pkg::MODE_REGISTER: begin
            tbl_valid[ix]   = 1'b1;
            tbl_timeout[ix] = c.device_timeout_ms;
            tbl_beeps[ix]   = c.device_beep_count;
            tbl_enabled[ix] = c.device_enable;
            tbl_down[ix]    = 1'b0;
            tbl_seen[ix]    = c.timestamp_ms;
         end
         default: begin
            if (tbl_valid[ix]) tbl_enabled[ix] = c.device_enable;
         end
      endcase
      r.addressed_offline = !(tbl_valid[ix] && !tbl_down[ix]);
      r.buzzer_on         = out_buzz;
      r.led_colour        = out_led;
      r.silent_error      = out_silent;
      r.audible_fault     = out_audible;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [3:0] got, logic [3:0] want);
      $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // ------------------------------------------------------------------
   // Driver: one command per transfer, random gaps, occasional drain
   // ------------------------------------------------------------------
   int   gap_left   = 0;
   logic drain_hold = 1'b0;

   always @(posedge clock) begin : driver
      logic next_start;
      next_start = start;
      if (reset) begin
         next_start = 1'b0;
      end else begin
         if (start && !busy) begin
            // transfer at this edge: predict from the command on the pins
            expected_status.push_back(predict_status(cmd));
            cmds_sent++;
            if (cmd.mode == htam_pkg::MODE_TICK) ticks_sent++;
            next_start = 1'b0;
         end
         if (!next_start) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (drain_hold) begin
               // hold off until every outstanding status has come back
               if (expected_status.size() == 0) drain_hold = 1'b0;
            end else if (pending_cmds.size() > 0) begin
               if (!steady && $urandom_range(0, 6) == 0) begin
                  gap_left = $urandom_range(0, 8);   // random idle gap before the next command
               end else if (!steady && $urandom_range(0, 60) == 0) begin
                  drain_hold = 1'b1;
               end else begin
                  cmd <= pending_cmds.pop_front();
                  next_start = 1'b1;
               end
            end
         end
      end
      start <= next_start;
   end

   // ------------------------------------------------------------------
   // Monitor: every strobed status is checked against the oldest prediction
   // ------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      htam_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         status_seen++;
         if (expected_status.size() == 0) begin
            report_mismatch("status with no command outstanding", 4'(rsp.led_colour), 4'd0);
         end else begin
            want = expected_status.pop_front();
            if (rsp.addressed_offline !== want.addressed_offline)
               report_mismatch("addressed_offline", 4'(rsp.addressed_offline),
                               4'(want.addressed_offline));
            if (rsp.buzzer_on !== want.buzzer_on)
               report_mismatch("buzzer_on", 4'(rsp.buzzer_on), 4'(want.buzzer_on));
            if (rsp.led_colour !== want.led_colour)
               report_mismatch("led_colour", 4'(rsp.led_colour), 4'(want.led_colour));
            if (rsp.silent_error !== want.silent_error)
               report_mismatch("silent_error", 4'(rsp.silent_error), 4'(want.silent_error));
            if (rsp.audible_fault !== want.audible_fault)
               report_mismatch("audible_fault", 4'(rsp.audible_fault),
                               4'(want.audible_fault));
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog on the whole run
   // ------------------------------------------------------------------
   initial begin : run_limit
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[%0t] timeout: %0d status words still outstanding", $time,
               expected_status.size());
      $display("tb_heartbeat_timeout_alarm_monitor: FAIL");
      $finish;
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic push_cmd(htam_pkg::mode_type m, logic [31:0] ts, logic [3:0] ix,
                           logic [31:0] tmo, logic [7:0] beeps, logic en);
      htam_pkg::req_type c;
      c.mode              = m;
      c.timestamp_ms      = ts;
      c.device_index      = ix;
      c.device_timeout_ms = tmo;
      c.device_beep_count = beeps;
      c.device_enable     = en;
      pending_cmds.push_back(c);
   endtask

   // Registers only change while nothing is in flight.
   task automatic write_csr(htam_pkg::csr_index_type ix, logic [15:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= ix;
      csr_wdata <= val;
      case (ix)
         htam_pkg::CSR_BEEP_ENABLE:  cfg_beep   = val[0];
         htam_pkg::CSR_ALARM_PERIOD: cfg_period = val;
         htam_pkg::CSR_BLINK_ON:     cfg_on     = val;
         default:                    cfg_cycle  = val;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Wait until the driver is empty and every status has been checked.
   task automatic wait_quiet();
      do @(posedge clock);
      while (pending_cmds.size() != 0 || start || drain_hold || expected_status.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // Mostly plausible traffic: time creeps forward, slots beat, a few go quiet.
   task automatic queue_traffic(int fresh, int count);
      htam_pkg::req_type c;
      int                pick;
      // a handful of well-formed registrations open each phase
      repeat (fresh) begin
         now_ms = now_ms + $urandom_range(0, 10);
         push_cmd(htam_pkg::MODE_REGISTER, now_ms, 4'($urandom_range(0, NSLOTS - 1)),
                  $urandom_range(10, 400), 8'($urandom_range(0, 4)), 1'b1);
      end
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 3)      now_ms = $urandom();                          // far jump
         else if (pick < 5) now_ms = now_ms - $urandom_range(1, 200);     // clock steps back
         else               now_ms = now_ms + $urandom_range(0, 40);
         c.timestamp_ms      = now_ms;
         c.device_index      = 4'($urandom_range(0, NSLOTS - 1));
         c.device_timeout_ms = $urandom();
         c.device_beep_count = 8'($urandom());
         c.device_enable     = 1'($urandom_range(0, 1));
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            c.mode = htam_pkg::MODE_TICK;
         end else if (pick < 75) begin
            c.mode = htam_pkg::MODE_BEAT;
            // keep a few slots healthy so both states are common
            if ($urandom_range(0, 1) == 0) c.device_index = 4'($urandom_range(0, 3));
         end else if (pick < 88) begin
            c.mode = htam_pkg::MODE_REGISTER;
            if ($urandom_range(0, 9) != 0) begin
               c.device_timeout_ms = $urandom_range(10, 400);
               c.device_beep_count = 8'($urandom_range(0, 4));
               c.device_enable     = ($urandom_range(0, 5) != 0);
            end
         end else begin
            c.mode = htam_pkg::MODE_ENABLE;
         end
         pending_cmds.push_back(c);
      end
   endtask

   task automatic run_phase(logic [15:0] beep_word, logic [15:0] per, logic [15:0] on,
                            logic [15:0] cyc, int fresh, int count);
      write_csr(htam_pkg::CSR_BEEP_ENABLE, beep_word);
      write_csr(htam_pkg::CSR_ALARM_PERIOD, per);
      write_csr(htam_pkg::CSR_BLINK_ON, on);
      write_csr(htam_pkg::CSR_BLINK_CYCLE, cyc);
      settings_used++;
      queue_traffic(fresh, count);
      wait_quiet();
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin : main
      logic [15:0] on_len;
      for (int i = 0; i < NSLOTS; i++) begin
         tbl_valid[i]   = 1'b0;
         tbl_enabled[i] = 1'b0;
         tbl_down[i]    = 1'b0;
         tbl_timeout[i] = '0;
         tbl_beeps[i]   = '0;
         tbl_seen[i]    = '0;
      end
      per_start   = '0;
      blk_start   = '0;
      blk_left    = '0;
      out_buzz    = 1'b0;
      out_led     = htam_pkg::LAMP_GREEN;
      out_silent  = 1'b0;
      out_audible = 1'b0;
      cfg_beep    = htam_pkg::BEEP_ENABLE_RST;
      cfg_period  = htam_pkg::ALARM_PERIOD_RST;
      cfg_on      = htam_pkg::BLINK_ON_RST;
      cfg_cycle   = htam_pkg::BLINK_CYCLE_RST;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed pass on the reset settings (period 2000, on 100, cycle 200).
      push_cmd(htam_pkg::MODE_TICK,     32'd0,    4'd3,  32'd0, 8'd0, 1'b0);  // empty, green
      push_cmd(htam_pkg::MODE_BEAT,     32'd5,    4'd3,  32'd0, 8'd0, 1'b0);  // unregistered
      push_cmd(htam_pkg::MODE_ENABLE,   32'd8,    4'd4,  32'd0, 8'd0, 1'b1);  // unregistered
      push_cmd(htam_pkg::MODE_REGISTER, 32'd10,   4'd0,  32'hFFFF_FFFF, 8'd255, 1'b1);
      push_cmd(htam_pkg::MODE_REGISTER, 32'd20,   4'd15, 32'd0, 8'd0, 1'b1);  // silent, 0 tmo
      push_cmd(htam_pkg::MODE_TICK,     32'd30,   4'd15, 32'd0, 8'd0, 1'b0);  // silent, red
      push_cmd(htam_pkg::MODE_REGISTER, 32'd40,   4'd1,  32'd100, 8'd3, 1'b1);
      push_cmd(htam_pkg::MODE_TICK,     32'd400,  4'd1,  32'd0, 8'd0, 1'b0);  // period not up
      push_cmd(htam_pkg::MODE_TICK,     32'd2500, 4'd1,  32'd0, 8'd0, 1'b0);  // reload, on
      push_cmd(htam_pkg::MODE_TICK,     32'd2550, 4'd0,  32'd0, 8'd0, 1'b0);
      push_cmd(htam_pkg::MODE_TICK,     32'd2650, 4'd1,  32'd0, 8'd0, 1'b0);  // dark phase
      push_cmd(htam_pkg::MODE_TICK,     32'd2720, 4'd1,  32'd0, 8'd0, 1'b0);  // blink ends
      push_cmd(htam_pkg::MODE_BEAT,     32'd2730, 4'd1,  32'd0, 8'd0, 1'b0);
      push_cmd(htam_pkg::MODE_ENABLE,   32'd2735, 4'd15, 32'd0, 8'd0, 1'b0);  // disable
      push_cmd(htam_pkg::MODE_TICK,     32'd2740, 4'd15, 32'd0, 8'd0, 1'b0);  // flag kept
      push_cmd(htam_pkg::MODE_REGISTER, 32'd2750, 4'd1,  32'd5, 8'd1, 1'b1);  // re-register
      push_cmd(htam_pkg::MODE_BEAT,     32'hFFFF_FFF0, 4'd0, 32'd0, 8'd0, 1'b0);
      push_cmd(htam_pkg::MODE_TICK,     32'hFFFF_FFFF, 4'd1, 32'hFFFF_FFFF, 8'hFF, 1'b1);
      push_cmd(htam_pkg::MODE_TICK,     32'h0000_0010, 4'd0, 32'd0, 8'd0, 1'b0);  // wraps
      push_cmd(htam_pkg::MODE_ENABLE,   32'h0000_0020, 4'd15, 32'd0, 8'd0, 1'b1);
      push_cmd(htam_pkg::MODE_REGISTER, 32'h0000_0030, 4'd2, 32'd50, 8'd0, 1'b0);  // silent
      push_cmd(htam_pkg::MODE_TICK,     32'h0000_0400, 4'd2, 32'd0, 8'd0, 1'b0);
      wait_quiet();
      now_ms = 32'h0000_0400;

      // Short alarm pattern with a fast blink.
      run_phase(16'd1, 16'd300, 16'd20, 16'd45, 6, 140);
      // Buzzer masked; shortest period, longest blink.
      run_phase(16'd0, 16'd1, 16'hFFFF, 16'hFFFF, 4, 90);
      // Longest period, shortest blink, run across the 32-bit wrap; stray upper bits.
      now_ms = 32'hFFFF_FE00;
      run_phase({15'($urandom_range(0, 16'h7FFF)), 1'b1}, 16'hFFFF, 16'd1, 16'd1, 4, 80);
      // Zero on phase: blinks go straight to dark.
      run_phase(16'd1, 16'd120, 16'd0, 16'd30, 4, 70);
      // Final stretch back to back, random timing.
      steady = 1'b1;
      on_len = 16'($urandom_range(1, 60));
      run_phase(16'd1, 16'($urandom_range(50, 400)), on_len,
                on_len + 16'($urandom_range(0, 60)), 4, 120);

      $display("covered %0d commands (%0d ticks), %0d status words checked",
               cmds_sent, ticks_sent, status_seen);
      $display("register settings used: reset defaults plus %0d written sets", settings_used);
      if (mismatches == 0 && expected_status.size() == 0) begin
         $display("tb_heartbeat_timeout_alarm_monitor: PASS");
      end else begin
         $display("tb_heartbeat_timeout_alarm_monitor: FAIL");
      end
      $finish;
   end

endmodule
